### src/tcm_pkg.sv
package tcm_pkg;

  // register indexes of the configuration port
  localparam logic REG_SENSOR_MAX_X = 1'b0;
  localparam logic REG_SENSOR_MAX_Y = 1'b1;

  localparam int RAW_W     = 16;
  localparam int COORD_W   = 9;
  localparam int COUNT_W   = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] MIN_POINT_BYTES = 4'd5;
  localparam logic [RAW_W-1:0]   SENSOR_MAX_RST  = 16'd479;

  // control bits that travel with a word along the divider row
  typedef struct packed {
    logic valid;
    logic ok;
    logic clr;
    logic pass_x;
    logic pass_y;
  } tcm_ctl_t;

endpackage

### src/touch_coordinate_mapper.sv
// touch_coordinate_mapper
//
// in_* channel: one word per touch report. in_tdata, from bit 0 up:
//   report_ready(1), touch_count(4), bytes_received(4), raw_x_coord(16),
//   raw_y_coord(16), zero fill to 48 bits.
// out_* channel: one word per report. out_tdata, from bit 0 up:
//   pressed(1), point_x(9), point_y(9), clear_status(1), zero fill to 24 bits.
// cfg_*: write port for sensor_max_x (index 0) and sensor_max_y (index 1),
//   written on any edge with cfg_we high; change them only while idle.
// path: QW being the bits of the larger panel maximum, a word taken by the
//   accepting edge loads the multiply-add stage, then passes one divider
//   cell per quotient bit, then the output register.
// throughput: one word per cycle unless the output stalls; every divider
//   cell works on a different word, so the row holds up to QW + 2 reports at once.
// reset: all valid bits clear, both sensor maxima go to 479.
// stall: while out_tvalid is high and out_tready low the whole row freezes
//   and in_tready drops; a taken output word frees the row in the same cycle.
module touch_coordinate_mapper import tcm_pkg::*; #(
  parameter int PANEL_MAX_X = 479,
  parameter int PANEL_MAX_Y = 479
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [RAW_W-1:0]      cfg_wdata,
  // reports
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ready, count, bytes, raw x, raw y
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // pressed, point x, point y, clear
);

  localparam int PMAX_BIG = (PANEL_MAX_X > PANEL_MAX_Y) ? PANEL_MAX_X : PANEL_MAX_Y;
  // quotient bits: the scaled value never exceeds the panel maximum
  localparam int QW = $clog2(PMAX_BIG + 1);
  localparam int XW = (QW > COORD_W) ? QW : COORD_W;

  // configuration registers
  logic [RAW_W-1:0] smax_x_r, smax_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smax_x_r <= SENSOR_MAX_RST;
      smax_y_r <= SENSOR_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_MAX_X: smax_x_r <= cfg_wdata;
        REG_SENSOR_MAX_Y: smax_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the report word
  logic               rep_ready;
  logic [COUNT_W-1:0] rep_count, rep_bytes;
  logic [RAW_W-1:0]   raw_x, raw_y;

  assign rep_ready = in_tdata[0];
  assign rep_count = in_tdata[4:1];
  assign rep_bytes = in_tdata[8:5];
  assign raw_x     = in_tdata[24:9];
  assign raw_y     = in_tdata[40:25];

  // whole row moves together; it only stops on a stalled output word
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // front stage: report checks and the multiply-add of each axis
  logic valid0_r, okb0_r, clr0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (en) begin
      valid0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okb0_r <= rep_ready && (rep_count != '0) && (rep_bytes >= MIN_POINT_BYTES);
      clr0_r <= rep_ready;
    end
  end

  logic [RAW_W-1:0] rem_x0, rem_y0;
  logic [QW-1:0]    low_x0, low_y0;
  logic             pass_x0, pass_y0, rok_x0, rok_y0;

  tcm_scale_in #(.QW(QW), .PMAX(PANEL_MAX_X)) u_scale_x (
    .clk    (clk),
    .en     (en),
    .raw    (raw_x),
    .smax   (smax_x_r),
    .rem_r  (rem_x0),
    .low_r  (low_x0),
    .pass_r (pass_x0),
    .rok_r  (rok_x0)
  );

  tcm_scale_in #(.QW(QW), .PMAX(PANEL_MAX_Y)) u_scale_y (
    .clk    (clk),
    .en     (en),
    .raw    (raw_y),
    .smax   (smax_y_r),
    .rem_r  (rem_y0),
    .low_r  (low_y0),
    .pass_r (pass_y0),
    .rok_r  (rok_y0)
  );

  // divider row: cell k produces quotient bit QW-1-k of both axes
  tcm_ctl_t         ctl_c   [0:QW];
  logic [RAW_W-1:0] rem_x_c [0:QW];
  logic [RAW_W-1:0] rem_y_c [0:QW];
  logic [QW-1:0]    low_x_c [0:QW];
  logic [QW-1:0]    low_y_c [0:QW];

  assign ctl_c[0] = '{valid:  valid0_r,
                      ok:     okb0_r && rok_x0 && rok_y0,
                      clr:    clr0_r,
                      pass_x: pass_x0,
                      pass_y: pass_y0};

  assign rem_x_c[0] = rem_x0;
  assign rem_y_c[0] = rem_y0;
  assign low_x_c[0] = low_x0;
  assign low_y_c[0] = low_y0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    tcm_cell #(.QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .div_x   (smax_x_r),
      .div_y   (smax_y_r),
      .ctl_i   (ctl_c[k]),
      .rem_x_i (rem_x_c[k]),
      .low_x_i (low_x_c[k]),
      .rem_y_i (rem_y_c[k]),
      .low_y_i (low_y_c[k]),
      .ctl_r   (ctl_c[k+1]),
      .rem_x_r (rem_x_c[k+1]),
      .low_x_r (low_x_c[k+1]),
      .rem_y_r (rem_y_c[k+1]),
      .low_y_r (low_y_c[k+1])
    );
  end

  // rotate and mirror: panel x is scaled y, panel y is max y minus scaled x
  logic [XW-1:0]      sx_w, sy_w, py_w;
  logic               press_ok;
  logic               pressed_r, clear_r;
  logic [COORD_W-1:0] point_x_r, point_y_r;

  assign sx_w     = XW'(low_x_c[QW]);
  assign sy_w     = XW'(low_y_c[QW]);
  assign py_w     = XW'(PANEL_MAX_Y) - sx_w;
  assign press_ok = ctl_c[QW].ok && (sx_w <= XW'(PANEL_MAX_Y)) &&
                    (sy_w <= XW'(PANEL_MAX_X)) &&
                    (XW'(low_x_c[QW]) <= XW'(PANEL_MAX_X)) &&
                    (XW'(low_y_c[QW]) <= XW'(PANEL_MAX_Y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_c[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pressed_r <= press_ok;
      clear_r   <= ctl_c[QW].clr;
      point_x_r <= press_ok ? sy_w[COORD_W-1:0] : '0;
      point_y_r <= press_ok ? py_w[COORD_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, clear_r, point_y_r, point_x_r, pressed_r};

  // a press always comes from a ready report
  a_press_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pressed_r |-> clear_r)
    else $error("press without ready flag");

  // released words carry zero coordinates
  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pressed_r |-> (point_x_r == '0) && (point_y_r == '0))
    else $error("released word with nonzero point");

  // right after reset neither the first divider cell nor the output holds a valid word
  a_first_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid_r && !ctl_c[1].valid)
    else $error("valid word right after reset");

endmodule

### src/tcm_scale_in.sv
module tcm_scale_in import tcm_pkg::*; #(
  parameter int QW   = 9,
  parameter int PMAX = 479
) (
  input  logic             clk,
  input  logic             en,
  input  logic [RAW_W-1:0] raw,
  input  logic [RAW_W-1:0] smax,
  output logic [RAW_W-1:0] rem_r,
  output logic [QW-1:0]    low_r,
  output logic             pass_r,
  output logic             rok_r
);

  localparam int NW = RAW_W + QW + 1;

  logic [NW-1:0]    num;
  logic             pass;
  logic             rok;
  logic [RAW_W-1:0] rem_nxt;
  logic [QW-1:0]    low_nxt;

  // numerator of the rounded division: raw * pmax + smax / 2
  assign num  = NW'(raw) * NW'(PMAX) + NW'(smax >> 1);
  assign pass = (smax == '0);
  assign rok  = pass ? (NW'(raw) <= NW'(PMAX)) : (raw <= smax);

  always_comb begin
    rem_nxt = num[QW +: RAW_W];
    low_nxt = pass ? raw[QW-1:0] : num[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      pass_r <= pass;
      rok_r  <= rok;
    end
  end

endmodule

### src/tcm_cell.sv
module tcm_cell import tcm_pkg::*; #(
  parameter int QW = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [RAW_W-1:0] div_x,
  input  logic [RAW_W-1:0] div_y,
  input  tcm_ctl_t         ctl_i,
  input  logic [RAW_W-1:0] rem_x_i,
  input  logic [QW-1:0]    low_x_i,
  input  logic [RAW_W-1:0] rem_y_i,
  input  logic [QW-1:0]    low_y_i,
  output tcm_ctl_t         ctl_r,
  output logic [RAW_W-1:0] rem_x_r,
  output logic [QW-1:0]    low_x_r,
  output logic [RAW_W-1:0] rem_y_r,
  output logic [QW-1:0]    low_y_r
);

  logic [RAW_W:0]   trial_x, trial_y;
  logic [RAW_W-1:0] rem_x_nxt, rem_y_nxt;
  logic [QW-1:0]    low_x_nxt, low_y_nxt;
  tcm_ctl_t         ctl_nxt;

  // one restoring step per axis: shift in the next numerator bit, subtract if it fits
  assign trial_x = {rem_x_i, low_x_i[QW-1]};
  assign trial_y = {rem_y_i, low_y_i[QW-1]};

  always_comb begin
    ctl_nxt = ctl_i;
    if (ctl_i.pass_x) begin
      rem_x_nxt = rem_x_i;
      low_x_nxt = low_x_i;
    end else if (trial_x >= {1'b0, div_x}) begin
      rem_x_nxt = RAW_W'(trial_x - {1'b0, div_x});
      low_x_nxt = QW'({low_x_i, 1'b1});
    end else begin
      rem_x_nxt = trial_x[RAW_W-1:0];
      low_x_nxt = QW'({low_x_i, 1'b0});
    end
    if (ctl_i.pass_y) begin
      rem_y_nxt = rem_y_i;
      low_y_nxt = low_y_i;
    end else if (trial_y >= {1'b0, div_y}) begin
      rem_y_nxt = RAW_W'(trial_y - {1'b0, div_y});
      low_y_nxt = QW'({low_y_i, 1'b1});
    end else begin
      rem_y_nxt = trial_y[RAW_W-1:0];
      low_y_nxt = QW'({low_y_i, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl_r.ok     <= ctl_nxt.ok;
      ctl_r.clr    <= ctl_nxt.clr;
      ctl_r.pass_x <= ctl_nxt.pass_x;
      ctl_r.pass_y <= ctl_nxt.pass_y;
      rem_x_r      <= rem_x_nxt;
      low_x_r      <= low_x_nxt;
      rem_y_r      <= rem_y_nxt;
      low_y_r      <= low_y_nxt;
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcm_pkg::*;

  localparam int PANEL_X = 479;
  localparam int PANEL_Y = 479;
  // cycles with neither side moving a word before the run is called hung
  localparam int QUIET_LIMIT = 5000;
  // idle cycles added at the end of each drain
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;

  // one touch report; the last field sits in the lowest bits
  typedef struct packed {
    logic [RAW_W-1:0]   raw_y_coord;
    logic [RAW_W-1:0]   raw_x_coord;
    logic [COUNT_W-1:0] bytes_received;
    logic [COUNT_W-1:0] touch_count;
    logic               report_ready;
  } touch_report_t;

  // one mapped result
  typedef struct packed {
    logic               clear_status;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_x;
    logic               pressed;
  } touch_point_t;

  // holds its own copy of the sensor maxima and the points still owed by the block
  class touch_point_checker;
    touch_point_t   expected_points[$];
    logic [RAW_W-1:0] sensor_max_x;
    logic [RAW_W-1:0] sensor_max_y;
    int unsigned    panel_max_x;
    int unsigned    panel_max_y;
    int             errors;

    function new(int unsigned pmax_x, int unsigned pmax_y);
      panel_max_x  = pmax_x;
      panel_max_y  = pmax_y;
      sensor_max_x = SENSOR_MAX_RST;
      sensor_max_y = SENSOR_MAX_RST;
      errors       = 0;
    endfunction

    function void set_sensor_max(logic idx, logic [RAW_W-1:0] val);
      if (idx == REG_SENSOR_MAX_X) sensor_max_x = val;
      else sensor_max_y = val;
    endfunction

    // rounded scaling of one axis; zero return means the press is invalid
    function bit scale_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] smax,
                            int unsigned pmax, output int unsigned scaled);
      longint unsigned v;
      scaled = 0;
      if (smax == 0) begin
        if (raw > pmax) return 0;
        scaled = raw;
        return 1;
      end
      if (raw > smax) return 0;
      v = (64'(raw) * 64'(pmax) + 64'(smax >> 1)) / 64'(smax);
      if (v > pmax) return 0;
      scaled = int'(v);
      return 1;
    endfunction

    function touch_point_t map_report(touch_report_t rep);
      touch_point_t pt;
      int unsigned  sx, sy;
      bit           ok;
      pt = '0;
      ok = rep.report_ready && rep.touch_count != 0 && rep.bytes_received >= MIN_POINT_BYTES;
      if (ok) ok = scale_axis(rep.raw_x_coord, sensor_max_x, panel_max_x, sx);
      if (ok) ok = scale_axis(rep.raw_y_coord, sensor_max_y, panel_max_y, sy);
      // off-panel after rotation only shows up with unequal panel maxima
      if (ok && (sx > panel_max_y || sy > panel_max_x)) ok = 0;
      pt.pressed = ok;
      if (ok) begin
        pt.point_x = sy[COORD_W-1:0];
        pt.point_y = COORD_W'(panel_max_y - sx);
      end
      pt.clear_status = rep.report_ready;
      return pt;
    endfunction

    function void note_report(touch_report_t rep);
      expected_points.push_back(map_report(rep));
    endfunction

    function void check_point(touch_point_t got);
      touch_point_t exp_pt;
      if (expected_points.size() == 0) begin
        $error("unexpected word on out: %h", got);
        errors++;
        return;
      end
      exp_pt = expected_points.pop_front();
      if (got.pressed !== exp_pt.pressed) begin
        $error("pressed: expected %0d, actual %0d", exp_pt.pressed, got.pressed);
        errors++;
      end
      if (got.point_x !== exp_pt.point_x) begin
        $error("point_x: expected %0d, actual %0d", exp_pt.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== exp_pt.point_y) begin
        $error("point_y: expected %0d, actual %0d", exp_pt.point_y, got.point_y);
        errors++;
      end
      if (got.clear_status !== exp_pt.clear_status) begin
        $error("clear_status: expected %0d, actual %0d", exp_pt.clear_status,
               got.clear_status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = REG_SENSOR_MAX_X;
  logic [RAW_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // ready, count, bytes, raw x, raw y
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // pressed, point x, point y, clear

  // idle odds in percent, changed per phase
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int          quiet_cycles = 0;

  touch_point_checker points;

  touch_coordinate_mapper #(
    .PANEL_MAX_X (PANEL_X),
    .PANEL_MAX_Y (PANEL_Y)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure at the phase's rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // monitor: both handshakes seen with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) points.note_report(touch_report_t'(in_tdata[40:0]));
      if (out_tvalid && out_tready) points.check_point(touch_point_t'(out_tdata[19:0]));
    end
  end

  // watchdog on stretches where no word moves on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sender: random idle cycles, then hold the word until it is taken
  task automatic send_report(touch_report_t rep);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(touch_report_t)){1'b0}}, rep};
    do @(posedge clk); while (!in_tready);
  endtask

  // both registers in back-to-back cycles, only while the block is idle
  task automatic write_sensor_maxima(logic [RAW_W-1:0] max_x, logic [RAW_W-1:0] max_y);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SENSOR_MAX_X;
    cfg_wdata <= max_x;
    @(posedge clk);
    cfg_index <= REG_SENSOR_MAX_Y;
    cfg_wdata <= max_y;
    @(posedge clk);
    cfg_we    <= 1'b0;
    points.set_sensor_max(REG_SENSOR_MAX_X, max_x);
    points.set_sensor_max(REG_SENSOR_MAX_Y, max_y);
  endtask

  // pause the sender until every owed point has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (points.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic touch_report_t make_report(logic ready, int unsigned count,
                                                int unsigned nbytes, int unsigned rx,
                                                int unsigned ry);
    touch_report_t rep;
    rep.report_ready   = ready;
    rep.touch_count    = COUNT_W'(count);
    rep.bytes_received = COUNT_W'(nbytes);
    rep.raw_x_coord    = RAW_W'(rx);
    rep.raw_y_coord    = RAW_W'(ry);
    return rep;
  endfunction

  // raw value for a well-formed press, now and then just past the sensor max
  function automatic int unsigned pick_raw(logic [RAW_W-1:0] smax);
    int unsigned hi;
    if (smax == 0) return $urandom_range(540, 0);
    if ($urandom_range(9) == 0) begin
      hi = (smax + 64 > 65535) ? 65535 : smax + 64;
      return $urandom_range(hi, smax);
    end
    return $urandom_range(smax, 0);
  endfunction

  function automatic touch_report_t random_report();
    int unsigned nbytes;
    if ($urandom_range(99) < 75) begin
      // well-formed press with random content
      nbytes = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : $urandom_range(8, 5);
      return make_report(1'b1, $urandom_range(15, 1), nbytes,
                         pick_raw(points.sensor_max_x), pick_raw(points.sensor_max_y));
    end
    // noise: anything the fields can carry
    return make_report($urandom_range(1), $urandom_range(15), $urandom_range(15),
                       $urandom_range(65535), $urandom_range(65535));
  endfunction

  // corners of the current scaling: zero, the max itself, one past it
  task automatic send_axis_corners();
    int unsigned lim_x, lim_y;
    lim_x = (points.sensor_max_x == 0) ? PANEL_X : points.sensor_max_x;
    lim_y = (points.sensor_max_y == 0) ? PANEL_Y : points.sensor_max_y;
    send_report(make_report(1'b1, 1, 5, 0, lim_y));
    send_report(make_report(1'b1, 1, 5, lim_x, 0));
    send_report(make_report(1'b1, 2, 6, (lim_x < 65535) ? lim_x + 1 : lim_x, lim_y));
    send_report(make_report(1'b1, 2, 6, lim_x, (lim_y < 65535) ? lim_y + 1 : lim_y));
  endtask

  initial begin
    logic [RAW_W-1:0] phase_max_x[PHASES];
    logic [RAW_W-1:0] phase_max_y[PHASES];

    points = new(PANEL_X, PANEL_Y);

    // scaling settings per phase, extremes and pass-through among them
    phase_max_x = '{16'd479, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd65535, 16'd0, 16'd0};
    phase_max_y = '{16'd479, 16'd0, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd0};
    phase_max_x[6] = $urandom_range(65535);
    phase_max_y[6] = $urandom_range(65535);
    phase_max_x[7] = $urandom_range(2000, 1);
    phase_max_y[7] = $urandom_range(700, 100);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed reports at the reset scaling (479 on both axes)
    send_report(make_report(1'b0, 0, 0, 0, 0));           // all quiet
    send_report(make_report(1'b0, 3, 8, 100, 200));       // good point, no ready
    send_report(make_report(1'b1, 0, 8, 100, 200));       // ready, no touches
    send_report(make_report(1'b1, 1, 4, 100, 200));       // one byte short
    send_report(make_report(1'b1, 1, 5, 0, 0));           // origin
    send_report(make_report(1'b1, 15, 15, 479, 479));     // far corner
    send_report(make_report(1'b1, 1, 8, 480, 10));        // raw x above sensor max
    send_report(make_report(1'b1, 1, 8, 10, 480));        // raw y above sensor max
    send_report(make_report(1'b1, 5, 5, 240, 239));       // rounding around half
    send_report(make_report(1'b1, 15, 15, 65535, 65535)); // all ones
    send_report(make_report(1'b1, 1, 8, 1, 478));
    send_report(make_report(1'b0, 15, 15, 65535, 65535));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // config only with nothing in flight
      write_sensor_maxima(phase_max_x[ph], phase_max_y[ph]);
      case (ph % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 62;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 62;
        end
        default: begin
          sender_idle_pct    = 26;
          receiver_stall_pct = 26;
        end
      endcase
      send_axis_corners();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_report(random_report());
      drain();
    end

    receiver_stall_pct = 0;
    if (points.errors == 0 && points.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/tcm_pkg.sv
src/tcm_scale_in.sv
src/tcm_cell.sv
src/touch_coordinate_mapper.sv
verif/testbench.sv
